// ===== rtl/bucketed_transposition_table_core_assert.svh =====
// Assertion macros for the bucketed transposition table core.
// Included by modules that check their own control logic; no other dependencies.
`ifndef BUCKETED_TRANSPOSITION_TABLE_CORE_ASSERT_SVH
`define BUCKETED_TRANSPOSITION_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTT_ASSERT(label, prop, msg)
`define BTT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/btt_pkg.sv =====
// Package for the bucketed transposition table core: entry layout, FSM states,
// command and configuration codes and the mate score adjustment. No dependencies.
`timescale 1ns / 1ps
package btt_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int WAYS_DEF       = 4;
    localparam int TAG_BITS       = 32;
    localparam int TAG_SHIFT      = 32;
    localparam int CFG_W          = 15;

    localparam logic [CFG_W-1:0] MATE_THRESHOLD_RST = 15'd31744;
    localparam logic             CFG_MATE_VALUE     = 1'b0;
    localparam logic             CFG_MATE_THRESHOLD = 1'b1;

    typedef enum logic { CMD_PROBE = 1'b0, CMD_STORE = 1'b1 } cmd_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [15:0]         move;
        logic [15:0]         score;
        logic [7:0]          depth;
        logic [1:0]          bound;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // Move a mate-range score away from zero by ply (or toward zero when sub is set).
    function automatic logic [15:0] mate_adjust(
        input logic [15:0]      s,
        input logic [7:0]       ply,
        input logic             sub,
        input logic [CFG_W-1:0] thr
    );
        logic signed [17:0] sx;
        logic signed [17:0] mag;
        logic signed [17:0] d;
        logic signed [17:0] sum;
        logic signed [17:0] r;
        logic [15:0]        res;
        sx  = $signed({{2{s[15]}}, s});
        mag = s[15] ? -sx : sx;
        d   = sub ? -$signed({10'd0, ply}) : $signed({10'd0, ply});
        sum = mag + d;
        r   = s[15] ? -sum : sum;
        if (mag < $signed({3'd0, thr})) begin
            res = s;
        end else if (r > 18'sd32767) begin
            res = 16'h7fff;
        end else if (r < -18'sd32768) begin
            res = 16'h8000;
        end else begin
            res = r[15:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/bucketed_transposition_table_core.sv =====
// Top level of the bucketed transposition table: bucket memory, lookup and
// replacement logic, configuration register. Depends on btt_pkg and the assert header.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. The bucket row is read
// from the synchronous memory in the accept cycle and the chosen way is written
// back in the next, so no new request is taken until that write-back. The result
// appears on the found_* ports with done high for exactly one cycle, registered
// from the lookup state; the receiver cannot stall it.
// After reset the table is cleared one bucket row per cycle, all 2**INDEX_BITS
// rows, while busy stays high; configuration writes are taken during that time.
// Register 0 (mate value) is accepted but does not affect results.
`include "bucketed_transposition_table_core_assert.svh"
module bucketed_transposition_table_core #(
    parameter int INDEX_BITS = btt_pkg::INDEX_BITS_DEF,
    parameter int WAYS       = btt_pkg::WAYS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     cmd,
    input  logic [63:0]              key,
    input  logic [15:0]              best_move,
    input  logic signed [15:0]       eval,
    input  logic [7:0]               search_depth,
    input  logic [1:0]               bound_kind,
    input  logic [7:0]               plies_from_root,
    output logic                     done,
    output logic                     hit,
    output logic [15:0]              found_move,
    output logic signed [15:0]       found_score,
    output logic [7:0]               found_depth,
    output logic [1:0]               found_bound,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [btt_pkg::CFG_W-1:0] cfg_data
);

    localparam int ROWS  = 1 << INDEX_BITS;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [INDEX_BITS-1:0] LAST_ROW = '1;

    typedef btt_pkg::entry_t [WAYS-1:0] row_t;

    row_t mem [ROWS];

    btt_pkg::state_t state_reg, state_next;
    logic [INDEX_BITS-1:0]       clr_cnt_reg;
    logic [btt_pkg::CFG_W-1:0]   thr_reg;

    logic                        cmd_reg;
    logic [btt_pkg::TAG_BITS-1:0] tag_reg;
    logic [INDEX_BITS-1:0]       row_addr_reg;
    logic [15:0]                 move_reg;
    logic [15:0]                 eval_reg;
    logic [7:0]                  depth_reg;
    logic [1:0]                  bound_reg;
    logic [7:0]                  ply_reg;
    row_t                        rd_row_reg;

    logic                        done_reg;
    logic                        hit_reg;
    logic [15:0]                 move_out_reg;
    logic [15:0]                 score_out_reg;
    logic [7:0]                  depth_out_reg;
    logic [1:0]                  bound_out_reg;

    logic                        accept;
    logic                        mem_we;
    logic [INDEX_BITS-1:0]       mem_waddr;
    row_t                        mem_wdata;

    logic                        hit_f;
    logic [WAY_W-1:0]            hit_w;
    logic [WAY_W-1:0]            vic_w;
    logic [7:0]                  min_depth;
    logic [WAY_W-1:0]            slot;
    btt_pkg::entry_t             old_e;
    btt_pkg::entry_t             new_e;
    btt_pkg::entry_t             wr_e;
    row_t                        row_upd;
    logic [15:0]                 hit_score;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btt_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = btt_pkg::ST_IDLE;
                end
            end
            btt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = btt_pkg::ST_LOOKUP;
                end
            end
            btt_pkg::ST_LOOKUP:
            begin
                state_next = btt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btt_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        busy      = 1'b1;
        accept    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = row_addr_reg;
        mem_wdata = row_upd;
        case (state_reg)
            btt_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            btt_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            btt_pkg::ST_LOOKUP:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // hit search and victim selection
    always_comb
    begin
        hit_f     = 1'b0;
        hit_w     = '0;
        vic_w     = '0;
        min_depth = rd_row_reg[0].depth;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_f && rd_row_reg[w].tag == tag_reg)
            begin
                hit_f = 1'b1;
                hit_w = WAY_W'(w);
            end
            if (rd_row_reg[w].depth < min_depth)
            begin
                min_depth = rd_row_reg[w].depth;
                vic_w     = WAY_W'(w);
            end
        end
    end

    // replacement
    always_comb
    begin
        slot      = hit_f ? hit_w : vic_w;
        old_e     = rd_row_reg[slot];
        hit_score = btt_pkg::mate_adjust(old_e.score, ply_reg, 1'b1, thr_reg);
        new_e.tag   = tag_reg;
        new_e.move  = move_reg;
        new_e.score = btt_pkg::mate_adjust(eval_reg, ply_reg, 1'b0, thr_reg);
        new_e.depth = depth_reg;
        new_e.bound = bound_reg;
        wr_e = old_e;
        if (!hit_f)
        begin
            wr_e.tag = '0;
        end
        if ((cmd_reg == btt_pkg::CMD_STORE)
            && ((wr_e.tag != tag_reg) || (depth_reg >= old_e.depth)))
        begin
            wr_e = new_e;
        end
        row_upd       = rd_row_reg;
        row_upd[slot] = wr_e;
    end

    // bucket memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_row_reg <= mem[key[btt_pkg::TAG_SHIFT +: INDEX_BITS]];
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            tag_reg      <= key[btt_pkg::TAG_BITS-1:0];
            row_addr_reg <= key[btt_pkg::TAG_SHIFT +: INDEX_BITS];
            move_reg     <= best_move;
            eval_reg     <= eval;
            depth_reg    <= search_depth;
            bound_reg    <= bound_kind;
            ply_reg      <= plies_from_root;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == btt_pkg::ST_LOOKUP)
        begin
            hit_reg       <= hit_f;
            move_out_reg  <= hit_f ? old_e.move  : 16'd0;
            score_out_reg <= hit_f ? hit_score   : 16'd0;
            depth_out_reg <= hit_f ? old_e.depth : 8'd0;
            bound_out_reg <= hit_f ? old_e.bound : 2'd0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= btt_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            thr_reg     <= btt_pkg::MATE_THRESHOLD_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == btt_pkg::ST_LOOKUP);
            if (state_reg == btt_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we && cfg_index == btt_pkg::CFG_MATE_THRESHOLD)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign found_move  = move_out_reg;
    assign found_score = score_out_reg;
    assign found_depth = depth_out_reg;
    assign found_bound = bound_out_reg;

    `BTT_ASSERT(a_accept_gives_done, accept |-> ##2 done, "request without result")
    `BTT_ASSERT(a_done_from_lookup, done |-> $past(state_reg == btt_pkg::ST_LOOKUP), "stray done")
    `BTT_ASSERT(a_no_write_idle, mem_we |-> state_reg != btt_pkg::ST_IDLE, "write while idle")
    `BTT_ASSERT(a_miss_zero, done && !hit |-> found_move == 16'd0 && found_depth == 8'd0, "miss data")
    `BTT_ASSERT_ALWAYS(a_busy_in_reset, !rst_n |-> busy, "idle during reset")

endmodule
